@@ rtl/averaged_sensor_thermostat_macros.svh @@
// Assertion macros for the averaged sensor thermostat.
`ifndef AVERAGED_SENSOR_THERMOSTAT_MACROS_SVH
`define AVERAGED_SENSOR_THERMOSTAT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define AST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ast: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define AST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ast: next-cycle check failed");
`else
`define AST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/ast_pkg.sv @@
// Shared types and constants of the averaged sensor thermostat.
`default_nettype none
package ast_pkg;

  // Register widths
  localparam int unsigned THR_W      = 8;
  localparam int unsigned OFFSET_W   = 10;
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned DEG_W      = 16;
  localparam int unsigned MSTEP_W    = $clog2(GAIN_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_ON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_OFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd3;

  // Register reset values
  localparam logic signed [THR_W-1:0]  HEAT_ON_RST  = 8'sd0;
  localparam logic signed [THR_W-1:0]  HEAT_OFF_RST = 8'sd0;
  localparam logic [OFFSET_W-1:0]      OFFSET_RST   = 10'd578;
  localparam logic signed [GAIN_W-1:0] GAIN_RST     = -10'sd140;

  // Saturation limits of the temperature
  localparam logic [DEG_W-1:0] DEG_MAX = 16'h7FFF;
  localparam logic [DEG_W-1:0] DEG_MIN = 16'h8000;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } ast_div_stat_t;

endpackage
`default_nettype wire

@@ rtl/ast_serial_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ast_serial_div import ast_pkg::*; #(
  parameter int unsigned DVD_W = 13,
  parameter int unsigned DVS_W = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic      [DVD_W-1:0] quotient_o,
  output ast_div_stat_t         stat_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W);

  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[DVD_W-2:0], ge};
      rem_d  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

@@ rtl/averaged_sensor_thermostat.sv @@
// Averaged sensor thermostat: one poll in, the filtered temperature and heater state out.
// Steps: accept the poll, sum the N filled entries (S_SUM), N = filled entries, divide (S_DIV),
// prepare (S_PREP), run the 10-step shift-add multiplier (S_MUL) and present the result (S_DONE);
// a poll with an empty history gives no result. A new poll is stalled until the sequencer is back
// in S_IDLE. The output register lets a new poll start while a result waits.
// Reset: heater off, history empty, thresholds 0, offset 578, gain -140.
`default_nettype none
`include "averaged_sensor_thermostat_macros.svh"
module averaged_sensor_thermostat import ast_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 5,
  parameter int unsigned SCALE_SHIFT   = 9,
  parameter int unsigned SAMPLE_BITS   = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // poll channel
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   sample_ready_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_value_i,
  // result channel
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [DEG_W-1:0]     degrees_o,
  output logic                        heater_on_o,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(HISTORY_DEPTH);
  localparam int unsigned MAG_W  = (SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W;
  localparam int unsigned DIFF_W = MAG_W + 1;
  localparam int unsigned PROD_W = MAG_W + GAIN_W;

  localparam logic [PROD_W-1:0] POS_LIM = PROD_W'(32767);
  localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(32768);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]               state_q, state_d;
  logic signed [THR_W-1:0]  heat_on_q, heat_off_q;
  logic [OFFSET_W-1:0]      offset_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic [SAMPLE_BITS-1:0]   hist_q [HISTORY_DEPTH];
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [SUM_W-1:0]         acc_q, acc_d;
  logic [PROD_W-1:0]        mcand_q, mcand_d;
  logic [GAIN_W-1:0]        mplier_q, mplier_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [MSTEP_W-1:0]       mstep_q, mstep_d;
  logic                     neg_q, neg_d;
  logic                     heat_q, heat_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DEG_W-1:0]  deg_out_q, deg_out_d;

  logic                     in_acc;
  logic                     hist_push;
  logic [SUM_W-1:0]         sum_nx;
  logic [CNT_W-1:0]         cnt_nx;
  logic                     div_start;
  logic [SUM_W-1:0]         quotient;
  ast_div_stat_t            div_stat;
  logic [SAMPLE_BITS-1:0]   mean;
  logic [DIFF_W-1:0]        diff;
  logic [MAG_W-1:0]         dmag;
  logic [GAIN_W-1:0]        gmag;
  logic [PROD_W-1:0]        pshift;
  logic signed [DEG_W-1:0]  deg;
  logic                     out_free;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign hist_push = in_acc && sample_ready_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_on_q  <= HEAT_ON_RST;
      heat_off_q <= HEAT_OFF_RST;
      offset_q   <= OFFSET_RST;
      gain_q     <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEAT_ON:  heat_on_q  <= cfg_data_i[THR_W-1:0];
        REG_HEAT_OFF: heat_off_q <= cfg_data_i[THR_W-1:0];
        REG_OFFSET:   offset_q   <= cfg_data_i[OFFSET_W-1:0];
        REG_GAIN:     gain_q     <= cfg_data_i[GAIN_W-1:0];
      endcase
    end
  end

  // Sample history: a shift line, newest entry in slot 0
  always_ff @(posedge clk_i) begin
    if (hist_push) begin
      hist_q[0] <= sample_value_i;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  // Running sum over the filled entries, one entry a cycle
  assign sum_nx = acc_q + SUM_W'(hist_q[cnt_q[IDX_W-1:0]]);
  assign cnt_nx = cnt_q + 1'b1;

  // Mean to signed difference and magnitudes for the multiplier
  assign mean = quotient[SAMPLE_BITS-1:0];
  assign diff = DIFF_W'(mean) - DIFF_W'(offset_q);
  assign dmag = diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
  assign gmag = gain_q[GAIN_W-1] ? GAIN_W'(-gain_q) : gain_q;

  // Scale down toward zero, then saturate
  assign pshift = prod_q >> SCALE_SHIFT;
  always_comb begin
    if (neg_q) begin
      deg = (pshift > NEG_LIM) ? DEG_MIN : DEG_W'(-pshift);
    end else begin
      deg = (pshift > POS_LIM) ? DEG_MAX : pshift[DEG_W-1:0];
    end
  end

  ast_serial_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_nx),
    .divisor_i (fill_q),
    .quotient_o(quotient),
    .stat_o    (div_stat)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    prod_d      = prod_q;
    mstep_d     = mstep_q;
    neg_d       = neg_q;
    heat_d      = heat_q;
    deg_out_d   = deg_out_q;
    out_valid_d = out_valid_q;
    div_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (sample_ready_i && (fill_q < CNT_W'(HISTORY_DEPTH))) begin
            fill_d = fill_q + 1'b1;
          end
          // an empty history gives no word
          if (fill_d != '0) begin
            acc_d   = '0;
            cnt_d   = '0;
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        acc_d = sum_nx;
        cnt_d = cnt_nx;
        if (cnt_nx == fill_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        mcand_d  = PROD_W'(dmag);
        mplier_d = gmag;
        neg_d    = diff[DIFF_W-1] ^ gain_q[GAIN_W-1];
        prod_d   = '0;
        mstep_d  = '0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        // shift-add, one gain bit a cycle
        if (mplier_q[0]) begin
          prod_d = prod_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        mstep_d  = mstep_q + 1'b1;
        if (mstep_q == MSTEP_W'(GAIN_W - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          // hysteresis: turn-on test wins
          priority if (deg < heat_on_q) begin
            heat_d = 1'b1;
          end else if (deg > heat_off_q) begin
            heat_d = 1'b0;
          end
          deg_out_d   = deg;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      mcand_q     <= '0;
      mplier_q    <= '0;
      prod_q      <= '0;
      mstep_q     <= '0;
      neg_q       <= 1'b0;
      heat_q      <= 1'b0;
      deg_out_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      mcand_q     <= mcand_d;
      mplier_q    <= mplier_d;
      prod_q      <= prod_d;
      mstep_q     <= mstep_d;
      neg_q       <= neg_d;
      heat_q      <= heat_d;
      deg_out_q   <= deg_out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign degrees_o   = deg_out_q;
  assign heater_on_o = heat_q;

  // Checks
  `AST_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= CNT_W'(HISTORY_DEPTH))
  `AST_ASSERT_IMP(a_div_in_state, clk_i, rst_ni, div_stat.busy, state_q == S_DIV)
  `AST_ASSERT_IMP(a_word_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_DONE)
  `AST_ASSERT_NXT(a_empty_poll, clk_i, rst_ni, in_acc && !sample_ready_i && fill_q == '0,
                  state_q == S_IDLE && !$rose(out_valid_q))

endmodule
`default_nettype wire
